// File: sv/alids_pkg.sv
`timescale 1ns / 1ps

package alids_pkg;

  localparam int CAPACITY = 32;
  localparam int VALUE_W  = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 6;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_POS  = 3'd0,
    OP_INS_SORT = 3'd1,
    OP_DEL_POS  = 3'd2,
    OP_DEL_VAL  = 3'd3,
    OP_LIN_FIND = 3'd4,
    OP_BIN_FIND = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BS_RD,
    S_BS_CMP,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

// File: sv/alids_if.sv
`timescale 1ns / 1ps

interface alids_req_if import alids_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [CNT_W-1:0]          position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface alids_rsp_if import alids_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    found_position;
  logic [CNT_W-1:0]    count_after;

  modport source (output valid, output status, output found_position,
                  output count_after, input ready);
  modport sink (input valid, input status, input found_position,
                input count_after, output ready);
endinterface

// File: sv/array_list_insert_delete_search.sv
`timescale 1ns / 1ps

// Packed list of signed words with insert, delete and search requests.
// A request word arrives on req (operation, value, position) and is taken when
// valid and ready are both high; exactly one response word leaves on rsp
// (status, found_position, count_after) for every request.
// The list lives in a single synchronous RAM with a registered read, so each
// request walks the entries through that one read port and one write port.
// Every request is taken in the idle state and loads its response into the
// output register in the response state, which shows it on rsp; in between:
//   linear find, delete by value, sorted insert: read the entries one by one;
//   binary find: a read state and a compare state per halving step; inserts
//   and deletes: the shift state reads the entries to move and writes them back.
// A rejected request (full, bad position) or an unused code goes from the idle
// state straight to the response state.
// One request is worked on at a time; req.ready is high only while the
// sequencer is idle. A finished response sits in an output register, so the
// next request is taken while that word waits for the receiver. If the
// receiver stalls, the sequencer holds its next response until the output
// register is free. Reset clears the entry count and the control state only.

module array_list_insert_delete_search import alids_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  alids_req_if.sink   req,
  alids_rsp_if.source rsp
);

  state_t state, state_next;

  logic [CNT_W-1:0]          count, count_next;
  op_t                       op, op_next;
  logic signed [VALUE_W-1:0] val, val_next;

  // Scan pointer and the slot whose read data is compared this cycle.
  logic [CNT_W-1:0]  idx, idx_next;
  logic              cmp_vld, cmp_vld_next;
  logic [ADDR_W-1:0] cmp_idx, cmp_idx_next;

  // Binary search window [lo, hi) and the probed slot.
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hi, hi_next;
  logic [ADDR_W-1:0] mid, mid_next;
  logic [ADDR_W-1:0] mid_c;

  // Shift engine: reads left, source slot, pending write and its target.
  logic [CNT_W-1:0]  rem, rem_next;
  logic [ADDR_W-1:0] src, src_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_dst, pend_dst_next;
  logic              up, up_next;
  logic [ADDR_W-1:0] ins_idx, ins_idx_next;

  status_t           res_status, res_status_next;
  logic [CNT_W-1:0]  res_slot, res_slot_next;

  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [CNT_W-1:0]    out_slot, out_slot_next;
  logic [CNT_W-1:0]    out_count, out_count_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0]  rd_data;
  logic                hit;

  alids_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // A sorted insert stops at the first entry not less than the value; the
  // other scans stop at the first equal entry.
  assign hit = (op == OP_INS_SORT) ? ($signed(rd_data) >= val)
                                   : ($signed(rd_data) == val);

  assign mid_c = ADDR_W'(lo + ((hi - lo) >> 1));

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_slot;
  assign rsp.count_after    = out_count;

  always_comb begin
    state_next      = state;
    count_next      = count;
    op_next         = op;
    val_next        = val;
    idx_next        = idx;
    cmp_vld_next    = 1'b0;
    cmp_idx_next    = cmp_idx;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    rem_next        = rem;
    src_next        = src;
    pend_next       = pend;
    pend_dst_next   = pend_dst;
    up_next         = up;
    ins_idx_next    = ins_idx;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_slot_next   = out_slot;
    out_count_next  = out_count;
    ram_we          = 1'b0;
    ram_waddr       = pend_dst;
    ram_wdata       = rd_data;
    ram_raddr       = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next         = op_t'(req.operation);
          val_next        = req.value;
          res_status_next = ST_OK;
          res_slot_next   = '0;
          idx_next        = '0;
          pend_next       = 1'b0;
          case (req.operation) inside
            OP_INS_POS: begin
              if (count == CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
                state_next      = S_RESP;
              end else if (req.position == '0 ||
                           req.position > CNT_W'(count + 1'b1)) begin
                res_status_next = ST_BAD_POS;
                state_next      = S_RESP;
              end else begin
                ins_idx_next  = ADDR_W'(req.position - 1'b1);
                rem_next      = CNT_W'(count - req.position + 1'b1);
                src_next      = ADDR_W'(count - 1'b1);
                up_next       = 1'b1;
                res_slot_next = req.position;
                state_next    = S_SHIFT;
              end
            end
            OP_INS_SORT: begin
              if (count == CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
                state_next      = S_RESP;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_DEL_POS: begin
              if (req.position == '0 || req.position > count) begin
                res_status_next = ST_BAD_POS;
                state_next      = S_RESP;
              end else begin
                rem_next      = CNT_W'(count - req.position);
                src_next      = ADDR_W'(req.position);
                up_next       = 1'b0;
                res_slot_next = req.position;
                state_next    = S_SHIFT;
              end
            end
            OP_DEL_VAL, OP_LIN_FIND: begin
              state_next = S_SCAN;
            end
            OP_BIN_FIND: begin
              lo_next    = '0;
              hi_next    = count;
              state_next = S_BS_RD;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmp_vld && hit) begin
          res_slot_next = CNT_W'(cmp_idx) + 1'b1;
          case (op)
            OP_INS_SORT: begin
              ins_idx_next = cmp_idx;
              rem_next     = CNT_W'(count - CNT_W'(cmp_idx));
              src_next     = ADDR_W'(count - 1'b1);
              up_next      = 1'b1;
              state_next   = S_SHIFT;
            end
            OP_DEL_VAL: begin
              rem_next   = CNT_W'(count - CNT_W'(cmp_idx) - 1'b1);
              src_next   = cmp_idx + 1'b1;
              up_next    = 1'b0;
              state_next = S_SHIFT;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end else if (idx == count) begin
          if (op == OP_INS_SORT) begin
            // Nothing is as large: append at the end.
            ins_idx_next  = count[ADDR_W-1:0];
            res_slot_next = CNT_W'(count + 1'b1);
            rem_next      = '0;
            up_next       = 1'b1;
            state_next    = S_SHIFT;
          end else begin
            res_status_next = ST_NOT_FOUND;
            state_next      = S_RESP;
          end
        end else begin
          ram_raddr    = idx[ADDR_W-1:0];
          cmp_idx_next = idx[ADDR_W-1:0];
          cmp_vld_next = 1'b1;
          idx_next     = CNT_W'(idx + 1'b1);
        end
      end

      S_BS_RD: begin
        if (lo < hi) begin
          ram_raddr  = mid_c;
          mid_next   = mid_c;
          state_next = S_BS_CMP;
        end else begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_RESP;
        end
      end

      S_BS_CMP: begin
        if ($signed(rd_data) == val) begin
          res_slot_next = CNT_W'(mid) + 1'b1;
          state_next    = S_RESP;
        end else begin
          if (val > $signed(rd_data)) begin
            lo_next = CNT_W'(mid) + 1'b1;
          end else begin
            hi_next = CNT_W'(mid);
          end
          state_next = S_BS_RD;
        end
      end

      S_SHIFT: begin
        // Each cycle writes back the word read in the cycle before, two
        // slots away from the one being read now.
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_dst;
          ram_wdata = rd_data;
        end
        if (rem != '0) begin
          ram_raddr     = src;
          rem_next      = CNT_W'(rem - 1'b1);
          pend_next     = 1'b1;
          pend_dst_next = up ? src + 1'b1 : src - 1'b1;
          src_next      = up ? src - 1'b1 : src + 1'b1;
        end else if (!pend) begin
          if (up) begin
            ram_we     = 1'b1;
            ram_waddr  = ins_idx;
            ram_wdata  = val;
            count_next = CNT_W'(count + 1'b1);
          end else begin
            count_next = CNT_W'(count - 1'b1);
          end
          state_next = S_RESP;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_slot_next   = res_slot;
          out_count_next  = count;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      cmp_vld   <= cmp_vld_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    val        <= val_next;
    idx        <= idx_next;
    cmp_idx    <= cmp_idx_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    rem        <= rem_next;
    src        <= src_next;
    pend_dst   <= pend_dst_next;
    up         <= up_next;
    ins_idx    <= ins_idx_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    out_status <= out_status_next;
    out_slot   <= out_slot_next;
    out_count  <= out_count_next;
  end

endmodule

// File: sv/alids_ram.sv
`timescale 1ns / 1ps

module alids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/alids_chk.sv
`timescale 1ns / 1ps

module alids_chk import alids_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [CNT_W-1:0]    rsp_found_position,
  input logic [CNT_W-1:0]    rsp_count_after
);

  logic [1:0]       pending;
  logic [CNT_W-1:0] last_count;
  logic             req_acc;
  logic             rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_count <= '0;
    end else begin
      pending <= 2'(pending + {1'b0, req_acc} - {1'b0, rsp_acc});
      if (rsp_acc) begin
        last_count <= rsp_count_after;
      end
    end
  end

  // A response word is only ever offered for a request already taken, and
  // at most one further request is taken while a response waits.
  a_no_orphan_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 2'd0))
    else $error("response offered with no request outstanding");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many requests outstanding");

  // A failed request leaves the list alone; a good one moves the count by
  // at most one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> ((rsp_status != ST_OK && rsp_count_after == last_count) ||
                 (rsp_status == ST_OK &&
                  (rsp_count_after == last_count ||
                   rsp_count_after == CNT_W'(last_count + 1'b1) ||
                   rsp_count_after == CNT_W'(last_count - 1'b1)))))
    else $error("entry count moved unexpectedly");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_position) && $stable(rsp_count_after))
    else $error("stalled response word changed");

endmodule

bind array_list_insert_delete_search alids_chk u_chk (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found_position (rsp.found_position),
  .rsp_count_after    (rsp.count_after)
);

// File: dv/tb_array_list_insert_delete_search.sv
`timescale 1ns / 1ps

// Self-checking bench for the packed list block. Request words are driven on
// the falling edge and both channels are sampled on the rising edge, so the
// bench never races the block's own flops. A shadow copy of the list
// predicts every response word at the moment its request word is accepted.
// A separate process compares each accepted response word with the oldest
// prediction.

module tb_array_list_insert_delete_search;
  import alids_pkg::*;

  // Codes 6 and 7 are not operations; the block must answer them with a
  // plain OK and leave the list alone.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // The longest quiet stretch of a correct run is one full-length scan and
  // shift plus a sender gap and a receiver stall. The limit is many times that.
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  alids_req_if req_ch ();
  alids_rsp_if rsp_ch ();

  array_list_insert_delete_search i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list and the predictions still waiting for a word.
  logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
  int                        shadow_count;
  outcome_t                  pending_rsp [$];

  int error_count;
  int requests_sent;
  int responses_seen;
  int peak_fill;
  int status_tally [4];

  // When clear, neither side idles; the closing part of the run uses this.
  bit sender_idles;
  bit receiver_idles;

  // ---------------------------------------------------------------------
  // Shadow list helpers.
  // ---------------------------------------------------------------------

  // Opens a hole at index idx and writes the new entry into it.
  function automatic void shadow_open(int idx, logic signed [VALUE_W-1:0] val);
    for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = val;
    shadow_count++;
  endfunction

  // Closes the entry at index idx, pulling later entries down.
  function automatic void shadow_close(int idx);
    for (int i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
  endfunction

  // Returns the 1-based slot of the first entry equal to val, or 0.
  function automatic int shadow_first_match(logic signed [VALUE_W-1:0] val);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_list[i] == val) return i + 1;
    end
    return 0;
  endfunction

  // Plain halving search over [lo, hi). On contents that are not ascending
  // it behaves exactly as the hardware's search does and may miss.
  function automatic int shadow_halving_search(logic signed [VALUE_W-1:0] val);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_list[mid] == val) return mid + 1;
      if (val > shadow_list[mid]) lo = mid + 1;
      else hi = mid;
    end
    return 0;
  endfunction

  // Applies one request word to the shadow list and returns the response
  // word the block must give for it.
  function automatic outcome_t apply_request(logic [OP_W-1:0] op,
                                             logic signed [VALUE_W-1:0] val,
                                             logic [CNT_W-1:0] pos);
    outcome_t r;
    int       slot;
    int       idx;
    r.status = ST_OK;
    slot     = 0;
    case (op)
      OP_INS_POS: begin
        // Full takes precedence over a bad position.
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else if (pos < 1 || pos > shadow_count + 1) r.status = ST_BAD_POS;
        else begin
          shadow_open(pos - 1, val);
          slot = pos;
        end
      end
      OP_INS_SORT: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else begin
          idx = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_list[i] >= val) begin
              idx = i;
              break;
            end
          end
          shadow_open(idx, val);
          slot = idx + 1;
        end
      end
      OP_DEL_POS: begin
        if (pos < 1 || pos > shadow_count) r.status = ST_BAD_POS;
        else begin
          shadow_close(pos - 1);
          slot = pos;
        end
      end
      OP_DEL_VAL: begin
        slot = shadow_first_match(val);
        if (slot == 0) r.status = ST_NOT_FOUND;
        else shadow_close(slot - 1);
      end
      OP_LIN_FIND: begin
        slot = shadow_first_match(val);
        if (slot == 0) r.status = ST_NOT_FOUND;
      end
      OP_BIN_FIND: begin
        slot = shadow_halving_search(val);
        if (slot == 0) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.slot  = slot[CNT_W-1:0];
    r.count = shadow_count[CNT_W-1:0];
    status_tally[r.status]++;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // A value that is often already in the list, often near zero (so that
  // duplicates are common), sometimes an extreme and otherwise anything.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: begin
        if (shadow_count > 0) return shadow_list[$urandom_range(0, shadow_count - 1)];
        return $urandom();
      end
      2: return $signed($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Mostly a position near the live range, now and then any 6-bit code.
  function automatic logic [CNT_W-1:0] pick_position();
    if ($urandom_range(0, 7) == 0) return CNT_W'($urandom_range(0, 63));
    return CNT_W'($urandom_range(0, shadow_count + 2));
  endfunction

  // Drives one request word and waits for it to be taken. The valid line is
  // left high afterwards, so back-to-back words need no dip in valid.
  task automatic send_word(input logic [OP_W-1:0] op,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [CNT_W-1:0] pos);
    int gap;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    req_ch.position  <= pos;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(apply_request(op, val, pos));
    requests_sent++;
  endtask

  // Holds the sender back until every predicted response word has come.
  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Short directed pass over the corner cases: every rejection on an empty
  // list, the value extremes, the ends of the position range, the spare
  // operation codes, duplicates and a halving search on unsorted contents.
  task automatic test_corner_cases();
    send_word(OP_DEL_POS, 32'sd0, 6'd1);           // delete on an empty list
    send_word(OP_DEL_VAL, 32'sd0, 6'd0);           // value absent
    send_word(OP_LIN_FIND, 32'sd0, 6'd0);
    send_word(OP_BIN_FIND, 32'sd0, 6'd0);
    send_word(OP_INS_POS, 32'sd1, 6'd0);           // position zero
    send_word(OP_INS_POS, 32'sd1, 6'd2);           // one past the end plus one
    send_word(OP_INS_POS, 32'sd1, 6'd63);          // top of the position field
    send_word(OP_SPARE_6, 32'sd9, 6'd1);
    send_word(OP_SPARE_7, 32'sd9, 6'd1);
    send_word(OP_INS_POS, 32'sh7fff_ffff, 6'd1);   // largest value
    send_word(OP_INS_SORT, 32'sh8000_0000, 6'd0);  // smallest value goes first
    send_word(OP_INS_POS, 32'sd0, 6'd3);           // append: list now unsorted
    send_word(OP_BIN_FIND, 32'sd0, 6'd0);          // halving search on unsorted data
    send_word(OP_LIN_FIND, 32'sh7fff_ffff, 6'd0);
    send_word(OP_DEL_POS, 32'sd0, 6'd4);           // one past the last entry
    send_word(OP_DEL_POS, 32'sd0, 6'd0);
    send_word(OP_DEL_VAL, 32'sd0, 6'd0);
    send_word(OP_DEL_POS, 32'sd0, 6'd2);           // deletes the largest value
    send_word(OP_INS_SORT, 32'sd5, 6'd0);          // goes past all entries
    send_word(OP_INS_SORT, 32'sd5, 6'd0);          // duplicate goes before its twin
    send_word(OP_LIN_FIND, 32'sd5, 6'd0);
    send_word(OP_BIN_FIND, 32'sd5, 6'd0);
    send_word(OP_SPARE_7, 32'sd5, 6'd63);          // spare code with entries held
    send_word(OP_DEL_POS, 32'sd0, 6'd1);
  endtask

  // Fills the list to capacity with a mix of positional and sorted inserts,
  // then checks that full wins over a bad position and that a freed slot can
  // be filled again.
  task automatic test_fill_to_capacity();
    logic signed [VALUE_W-1:0] val;
    hold_until_drained();
    while (shadow_count < CAPACITY) begin
      val = pick_value();
      if ($urandom_range(0, 1) == 0)
        send_word(OP_INS_POS, val, CNT_W'($urandom_range(1, shadow_count + 1)));
      else send_word(OP_INS_SORT, val, pick_position());
    end
    send_word(OP_INS_POS, pick_value(), 6'd0);
    send_word(OP_INS_POS, pick_value(), 6'd33);
    send_word(OP_INS_SORT, pick_value(), 6'd0);
    send_word(OP_LIN_FIND, shadow_list[CAPACITY-1], 6'd0);
    send_word(OP_DEL_POS, 32'sd0, 6'd33);
    send_word(OP_DEL_POS, 32'sd0, CAPACITY[CNT_W-1:0]);
    send_word(OP_INS_POS, pick_value(), CAPACITY[CNT_W-1:0]);
    send_word(OP_INS_POS, pick_value(), 6'd1);
    // Empty it again from random positions, so the sorted test starts clean.
    while (shadow_count > 0)
      send_word(OP_DEL_POS, 32'sd0, CNT_W'($urandom_range(1, shadow_count)));
    send_word(OP_DEL_POS, 32'sd0, 6'd1);
  endtask

  // Keeps the list ascending: only sorted inserts and deletes, so the
  // halving search must always agree with the linear one. The fill level is
  // steered towards a target that changes now and then, both ends included.
  task automatic test_sorted_traffic(input int items);
    int target;
    int choice;
    target = CAPACITY;
    for (int n = 0; n < items; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = CAPACITY;
          default: target = $urandom_range(0, CAPACITY);
        endcase
      end
      choice = $urandom_range(0, 9);
      if (choice < 4) begin
        if (shadow_count < target) send_word(OP_INS_SORT, pick_value(), pick_position());
        else if ($urandom_range(0, 1) == 0) send_word(OP_DEL_POS, pick_value(), pick_position());
        else send_word(OP_DEL_VAL, pick_value(), pick_position());
      end else if (choice < 7) begin
        send_word(OP_BIN_FIND, pick_value(), pick_position());
      end else if (choice < 9) begin
        send_word(OP_LIN_FIND, pick_value(), pick_position());
      end else begin
        send_word(OP_INS_SORT, pick_value(), pick_position());
      end
    end
  endtask

  // Every operation code with random fields, including the spare codes and
  // positional inserts that leave the contents out of order.
  task automatic test_random_mix(input int items);
    logic [OP_W-1:0] op;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 19) == 0) op = OP_W'($urandom_range(6, 7));
      else op = OP_W'($urandom_range(0, 5));
      send_word(op, pick_value(), pick_position());
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: ready drops now and then in bursts while idling is on.
  // ---------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response check: each accepted word against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      responses_seen++;
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("response word with none expected: status %0d slot %0d count %0d",
                                  rsp_ch.status, rsp_ch.found_position, rsp_ch.count_after));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                    responses_seen, rsp_ch.status, want.status));
        if (rsp_ch.found_position !== want.slot)
          report_mismatch($sformatf("response %0d found_position %0d, expected %0d",
                                    responses_seen, rsp_ch.found_position, want.slot));
        if (rsp_ch.count_after !== want.count)
          report_mismatch($sformatf("response %0d count_after %0d, expected %0d",
                                    responses_seen, rsp_ch.count_after, want.count));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too many cycles with no word accepted on either side.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int quiet;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: %0d cycles without progress, %0d responses outstanding",
               quiet, pending_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence of tests.
  // ---------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= '0;
    req_ch.value     <= '0;
    req_ch.position  <= '0;
    shadow_count   = 0;
    error_count    = 0;
    requests_sent  = 0;
    responses_seen = 0;
    peak_fill      = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_fill_to_capacity();
    test_sorted_traffic(850);
    hold_until_drained();
    test_random_mix(700);

    // Closing stretch at full rate on both sides.
    hold_until_drained();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_mix(250);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_rsp.size() != 0)
      report_mismatch($sformatf("%0d response words never arrived", pending_rsp.size()));

    $display("Covered %0d requests and %0d responses; the list peaked at %0d of %0d entries.",
             requests_sent, responses_seen, peak_fill, CAPACITY);
    $display("Outcomes: %0d ok, %0d not found, %0d full, %0d bad position; %0d mismatches.",
             status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_FULL],
             status_tally[ST_BAD_POS], error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/alids_pkg.sv
sv/alids_if.sv
sv/alids_ram.sv
sv/array_list_insert_delete_search.sv
sv/alids_chk.sv
dv/tb_array_list_insert_delete_search.sv
